@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/arp_pkg.sv @@
// ----------------------------------------------------------------------------
// arp_pkg
// Shared constants, frame size tables and controller/datapath interface types
// for the AMR RTP packetizer.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int MAX_FRAMES_PER_PACKET = 15;
  localparam int MAX_RESULTS           = 15;

  localparam logic [3:0] FRAME_LIMIT = 4'(MAX_FRAMES_PER_PACKET);
  localparam logic [3:0] LAST_COUNT  = 4'(MAX_RESULTS - 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDEBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_MTU = 2'd1;

  localparam logic [13:0] MTU_RESET = 14'd1450;

  // Speech bytes per frame type
  localparam logic [5:0] NB_SIZES [16] = '{
    6'd12, 6'd13, 6'd15, 6'd17, 6'd19, 6'd20, 6'd26, 6'd31,
    6'd5,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
  };
  localparam logic [5:0] WB_SIZES [16] = '{
    6'd17, 6'd23, 6'd32, 6'd36, 6'd40, 6'd46, 6'd50, 6'd58,
    6'd60, 6'd5,  6'd5,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
  };

  function automatic logic [5:0] speech_size(input logic wb, input logic [3:0] ft);
    return wb ? WB_SIZES[ft] : NB_SIZES[ft];
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture a new sample, start frame count
    logic tail_init;  // restart frame count against the remaining bytes
    logic step;       // add one frame to the running count
    logic latch_n;    // freeze frames per packet and packet size
    logic emit;       // write one packet descriptor to the output register
    logic tail;       // emitted packet is the short tail
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sample_zero; // offered sample is empty
    logic can_add;     // one more frame fits the current limit
    logic full;        // remaining bytes cover a whole packet
    logic last;        // full packet about to go out ends the sample
  } sts_t;

endpackage

@@ rtl/amr_rtp_packetizer.sv @@
// ----------------------------------------------------------------------------
// amr_rtp_packetizer
// Splits one AMR / AMR-WB sample into octet-aligned RTP packet descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per stored sample, giving
//   its first byte, its length and its timestamp. An empty sample is taken
//   and produces no packet.
//   Output channel (out_valid / out_stall): one beat per packet, up to 15
//   per sample; out_last_packet marks the final one.
//   Config channel (cfg_valid / cfg_ready, always ready): index 0 selects
//   the wideband size table, index 1 sets the path MTU. Write only when idle.
// Timing:
//   The frame counter adds one frame size per cycle. A sample is accepted,
//   its frames per packet are counted, each full packet is emitted, and a
//   short tail, if one remains, is counted and emitted. An empty sample is
//   only accepted. in_stall stays high until the last packet is in the
//   output reg.
// Reset: sequence counter cleared, narrowband table, MTU 1450, no beat out.
// Stall: the output register holds its packet; the sequencer waits before
//   writing the next one, nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module amr_rtp_packetizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_header_byte,
  input  logic [9:0]                    in_sample_bytes,
  input  logic [31:0]                   in_time_stamp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_seq_number,
  output logic [31:0]                   out_pkt_time,
  output logic [7:0]                    out_lead_byte,
  output logic [3:0]                    out_frame_count,
  output logic [7:0]                    out_toc_final_byte,
  output logic [9:0]                    out_data_offset,
  output logic [5:0]                    out_frame_bytes,
  output logic                          out_last_packet,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [13:0]                   cfg_data
);

  arp_pkg::cmd_t cmd;
  arp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer
  arp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  arp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_header_byte     (in_header_byte),
    .in_sample_bytes    (in_sample_bytes),
    .in_time_stamp      (in_time_stamp),
    .out_seq_number     (out_seq_number),
    .out_pkt_time       (out_pkt_time),
    .out_lead_byte      (out_lead_byte),
    .out_frame_count    (out_frame_count),
    .out_toc_final_byte (out_toc_final_byte),
    .out_data_offset    (out_data_offset),
    .out_frame_bytes    (out_frame_bytes),
    .out_last_packet    (out_last_packet)
  );

  // Checks
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && !in_stall, "not idle after reset")
  `ASSERT_CHK(a_emit_free, clk, rst_n, cmd.emit |-> (!out_valid || !out_stall), "emit over held beat")
  `ASSERT_CHK(a_emit_valid, clk, rst_n, cmd.emit |=> out_valid, "emitted packet not shown")
  `ASSERT_CHK(a_busy_after_take, clk, rst_n, (in_valid && !in_stall && !sts.sample_zero) |=> in_stall, "sample taken but not busy")

endmodule

@@ rtl/arp_ctrl.sv @@
// ----------------------------------------------------------------------------
// arp_ctrl
// Sequencer: sample accept, frame counting, packet emission and the
// output handshake.
// ----------------------------------------------------------------------------
module arp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  arp_pkg::sts_t sts,
  output arp_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT_N,
    S_PACK,
    S_COUNT_T,
    S_EMIT_T
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_stall_nxt = in_stall_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.sample_zero) begin
            state_nxt    = S_COUNT_N;
            in_stall_nxt = 1'b1;
          end
        end
      end
      S_COUNT_N: begin
        if (sts.can_add) begin
          cmd.step = 1'b1;
        end else begin
          cmd.latch_n = 1'b1;
          state_nxt   = S_PACK;
        end
      end
      S_PACK: begin
        if (!sts.full) begin
          cmd.tail_init = 1'b1;
          state_nxt     = S_COUNT_T;
        end else if (out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_nxt    = S_IDLE;
            in_stall_nxt = 1'b0;
          end
        end
      end
      S_COUNT_T: begin
        if (sts.can_add) begin
          cmd.step = 1'b1;
        end else begin
          state_nxt = S_EMIT_T;
        end
      end
      S_EMIT_T: begin
        if (out_free) begin
          cmd.emit     = 1'b1;
          cmd.tail     = 1'b1;
          state_nxt    = S_IDLE;
          in_stall_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_stall_nxt = 1'b0;
      end
    endcase
    out_valid_nxt = cmd.emit | (out_valid_r & out_stall);
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

@@ rtl/arp_dp.sv @@
// ----------------------------------------------------------------------------
// arp_dp
// Datapath: configuration registers, sample registers, frame counter,
// packet bookkeeping and the output descriptor register.
// ----------------------------------------------------------------------------
module arp_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  arp_pkg::cmd_t                  cmd,
  output arp_pkg::sts_t                  sts,
  input  logic                           cfg_valid,
  input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [13:0]                    cfg_data,
  input  logic [7:0]                     in_header_byte,
  input  logic [9:0]                     in_sample_bytes,
  input  logic [31:0]                    in_time_stamp,
  output logic [15:0]                    out_seq_number,
  output logic [31:0]                    out_pkt_time,
  output logic [7:0]                     out_lead_byte,
  output logic [3:0]                     out_frame_count,
  output logic [7:0]                     out_toc_final_byte,
  output logic [9:0]                     out_data_offset,
  output logic [5:0]                     out_frame_bytes,
  output logic                           out_last_packet
);

  // Configuration
  logic        wideband_r;
  logic [13:0] mtu_r;

  // Sample
  logic        f_r, q_r;
  logic [3:0]  ft_r;
  logic [5:0]  speech_r;
  logic [5:0]  fsize_r;
  logic [9:0]  rem_r;
  logic [31:0] ts_r;

  // Frame counter
  logic [9:0]  limit_r;
  logic [9:0]  acc_r;
  logic [3:0]  k_r;

  // Packet bookkeeping
  logic [3:0]  nframes_r;
  logic [9:0]  chunk_max_r;
  logic [9:0]  offset_r;
  logic [3:0]  count_r;
  logic [15:0] seq_r;

  logic [5:0]  in_speech;
  logic [9:0]  in_limit;
  logic [10:0] acc_sum;
  logic [3:0]  fc;
  logic [9:0]  chunk;
  logic [9:0]  rem_after;
  logic [15:0] seq_inc;

  assign in_speech = arp_pkg::speech_size(wideband_r, in_header_byte[6:3]);
  assign in_limit  = ({4'd0, in_sample_bytes} < mtu_r) ? in_sample_bytes : mtu_r[9:0];
  assign acc_sum   = {1'b0, acc_r} + {5'd0, fsize_r};

  assign fc        = cmd.tail ? k_r : nframes_r;
  assign chunk     = cmd.tail ? rem_r : chunk_max_r;
  assign rem_after = rem_r - chunk_max_r;
  assign seq_inc   = seq_r + 16'd1;

  // Status
  always_comb begin
    sts.sample_zero = (in_sample_bytes == 10'd0);
    sts.can_add     = (k_r != arp_pkg::FRAME_LIMIT) && (acc_sum <= {1'b0, limit_r});
    sts.full        = (rem_r >= chunk_max_r);
    sts.last        = (rem_after == 10'd0) || (nframes_r == 4'd0) ||
                      (count_r == arp_pkg::LAST_COUNT);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wideband_r <= 1'b0;
      mtu_r      <= arp_pkg::MTU_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        arp_pkg::REG_WIDEBAND: wideband_r <= cfg_data[0];
        arp_pkg::REG_PATH_MTU: mtu_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= 16'd0;
    end else if (cmd.emit) begin
      seq_r <= seq_inc;
    end
  end

  // Sample capture, frame counting and packet bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_r      <= in_header_byte[7];
      ft_r     <= in_header_byte[6:3];
      q_r      <= in_header_byte[2];
      speech_r <= in_speech;
      fsize_r  <= in_speech + 6'd1;
      rem_r    <= in_sample_bytes;
      ts_r     <= in_time_stamp;
      limit_r  <= in_limit;
      acc_r    <= 10'd0;
      k_r      <= 4'd0;
      offset_r <= 10'd0;
      count_r  <= 4'd0;
    end else begin
      if (cmd.tail_init) begin
        limit_r <= rem_r;
        acc_r   <= 10'd0;
        k_r     <= 4'd0;
      end
      if (cmd.step) begin
        acc_r <= acc_sum[9:0];
        k_r   <= k_r + 4'd1;
      end
      if (cmd.latch_n) begin
        nframes_r   <= k_r;
        chunk_max_r <= acc_r;
      end
      if (cmd.emit) begin
        rem_r    <= rem_r - chunk;
        offset_r <= offset_r + chunk;
        count_r  <= count_r + 4'd1;
      end
    end
  end

  // Output descriptor register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_seq_number     <= seq_inc;
      out_pkt_time       <= ts_r;
      out_lead_byte      <= {1'b1, ft_r, q_r, 2'b00};
      out_frame_count    <= fc;
      out_toc_final_byte <= (fc != 4'd0) ? {f_r, ft_r, q_r, 2'b00} : 8'd0;
      out_data_offset    <= (fc != 4'd0) ? (offset_r + 10'd1) : 10'd0;
      out_frame_bytes    <= speech_r;
      out_last_packet    <= cmd.tail | sts.last;
    end
  end

endmodule
